FILE: hw/rtl/ipd_pkg.sv
// ---------------------------------------------------------------------------
// ipd_pkg: shared types and constants of the IR pulse-distance decoder
// Register map, reset values, decoder phase codes and the structs that pass
// between the top level and the interval classifier.
// ---------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

   localparam int unsigned STAMP_W    = 16;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [STAMP_W-1:0] STAMP_MAX = 16'hFFFF;

   // Byte addresses of the configuration registers.
   localparam logic [CSR_ADDR_W-1:0] ADDR_LEADER_MIN = 5'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LEADER_MAX = 5'd4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_ONE_MIN    = 5'd8;
   localparam logic [CSR_ADDR_W-1:0] ADDR_ONE_MAX    = 5'd12;
   localparam logic [CSR_ADDR_W-1:0] ADDR_ZERO_MIN   = 5'd16;
   localparam logic [CSR_ADDR_W-1:0] ADDR_ZERO_MAX   = 5'd20;

   // Reset values of the window bounds, in timer ticks.
   localparam logic [STAMP_W-1:0] RST_LEADER_MIN = 16'd26500;
   localparam logic [STAMP_W-1:0] RST_LEADER_MAX = 16'd27500;
   localparam logic [STAMP_W-1:0] RST_ONE_MIN    = 16'd4280;
   localparam logic [STAMP_W-1:0] RST_ONE_MAX    = 16'd4680;
   localparam logic [STAMP_W-1:0] RST_ZERO_MIN   = 16'd2040;
   localparam logic [STAMP_W-1:0] RST_ZERO_MAX   = 16'd2440;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_FIRST = 2'd1,
      PH_RECV  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [STAMP_W-1:0] leader_min;
      logic [STAMP_W-1:0] leader_max;
      logic [STAMP_W-1:0] one_min;
      logic [STAMP_W-1:0] one_max;
      logic [STAMP_W-1:0] zero_min;
      logic [STAMP_W-1:0] zero_max;
   } cfg_type;

   typedef struct packed {
      logic leader_hit;
      logic one_hit;
      logic zero_hit;
   } match_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ipd_if.sv
// ---------------------------------------------------------------------------
// ipd_if: valid/ready channels of the IR pulse-distance decoder
// One interface for the edge timestamp channel and one for the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface ipd_req_if;
   logic                         valid;
   logic                         ready;
   logic [ipd_pkg::STAMP_W-1:0]  edge_time;

   modport source (output valid, output edge_time, input ready);
   modport sink   (input valid, input edge_time, output ready);
endinterface

interface ipd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         frame_ready;
   logic [ipd_pkg::VALUE_W-1:0]  frame_value;
   logic                         frame_done;
   logic                         pulse_rejected;

   modport source (output valid, output frame_ready, output frame_value,
                   output frame_done, output pulse_rejected, input ready);
   modport sink   (input valid, input frame_ready, input frame_value,
                   input frame_done, input pulse_rejected, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipd_classify.sv
// ---------------------------------------------------------------------------
// ipd_classify: edge interval and window match
// Computes the tick count between two timestamps, wrapping once, and tests
// it against the leader, one and zero windows (all bounds exclusive).
// ---------------------------------------------------------------------------
`default_nettype none

module ipd_classify (
   input  wire logic [ipd_pkg::STAMP_W-1:0] prev_stamp,
   input  wire logic [ipd_pkg::STAMP_W-1:0] cur_stamp,
   input  wire ipd_pkg::cfg_type            cfg,
   output ipd_pkg::match_type               match
);

   logic [ipd_pkg::STAMP_W-1:0] interval;

   // An equal or smaller stamp means the timer wrapped; the sum never
   // exceeds the full-scale value, so it fits in the stamp width.
   assign interval = (cur_stamp > prev_stamp) ? (cur_stamp - prev_stamp)
                                              : ((ipd_pkg::STAMP_MAX - prev_stamp) + cur_stamp);

   assign match.leader_hit = (interval > cfg.leader_min) && (interval < cfg.leader_max);
   assign match.one_hit    = (interval > cfg.one_min)    && (interval < cfg.one_max);
   assign match.zero_hit   = (interval > cfg.zero_min)   && (interval < cfg.zero_max);

endmodule

`default_nettype wire

FILE: hw/rtl/ir_pulse_distance_decoder.sv
// ---------------------------------------------------------------------------
// ir_pulse_distance_decoder: pulse-distance infrared frame decoder
// Turns falling-edge timestamps of an IR receiver into 32-bit frame codes.
// ---------------------------------------------------------------------------
// Usage:
// Each transfer on the req channel carries the free-running timer value
// captured at one falling edge of the receiver pin. For every accepted edge
// the block sends exactly one transfer on the rsp channel with the held
// frame status, the frame code, a done strobe and a reject strobe.
// An accepted edge sits in the input register, is classified and folded
// into the decoder state, and its result lands in the output register. One
// edge is taken every cycle while rsp is not stalled; the phase machine
// updates its state once for each edge. When the receiver stalls rsp, the
// result waits in the output register and the input register still takes
// one more edge before req backs off. Reset clears the decoder to idle with
// no stored edge and no frame held, and loads the window bounds with their
// default timings. The APB port writes and reads the six window bounds; the
// user writes it only while no edge is in flight, which the block itself
// does not enforce. pready is tied high.
// ---------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_decoder #(
   parameter int unsigned FRAME_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ipd_req_if.sink                             req,
   ipd_rsp_if.source                           rsp,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [ipd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [ipd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [ipd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);

   localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   ipd_pkg::cfg_type cfg_ff;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_min <= ipd_pkg::RST_LEADER_MIN;
         cfg_ff.leader_max <= ipd_pkg::RST_LEADER_MAX;
         cfg_ff.one_min    <= ipd_pkg::RST_ONE_MIN;
         cfg_ff.one_max    <= ipd_pkg::RST_ONE_MAX;
         cfg_ff.zero_min   <= ipd_pkg::RST_ZERO_MIN;
         cfg_ff.zero_max   <= ipd_pkg::RST_ZERO_MAX;
      end else if (csr_write) begin
         unique case (paddr)
            ipd_pkg::ADDR_LEADER_MIN: cfg_ff.leader_min <= pwdata[ipd_pkg::STAMP_W-1:0];
            ipd_pkg::ADDR_LEADER_MAX: cfg_ff.leader_max <= pwdata[ipd_pkg::STAMP_W-1:0];
            ipd_pkg::ADDR_ONE_MIN:    cfg_ff.one_min    <= pwdata[ipd_pkg::STAMP_W-1:0];
            ipd_pkg::ADDR_ONE_MAX:    cfg_ff.one_max    <= pwdata[ipd_pkg::STAMP_W-1:0];
            ipd_pkg::ADDR_ZERO_MIN:   cfg_ff.zero_min   <= pwdata[ipd_pkg::STAMP_W-1:0];
            ipd_pkg::ADDR_ZERO_MAX:   cfg_ff.zero_max   <= pwdata[ipd_pkg::STAMP_W-1:0];
            default: begin
               // Writes outside the register map are dropped.
            end
         endcase
      end
   end

   // Reads return the bound zero-extended to the data width.
   always_comb begin
      unique case (paddr)
         ipd_pkg::ADDR_LEADER_MIN: prdata = ipd_pkg::CSR_DATA_W'(cfg_ff.leader_min);
         ipd_pkg::ADDR_LEADER_MAX: prdata = ipd_pkg::CSR_DATA_W'(cfg_ff.leader_max);
         ipd_pkg::ADDR_ONE_MIN:    prdata = ipd_pkg::CSR_DATA_W'(cfg_ff.one_min);
         ipd_pkg::ADDR_ONE_MAX:    prdata = ipd_pkg::CSR_DATA_W'(cfg_ff.one_max);
         ipd_pkg::ADDR_ZERO_MIN:   prdata = ipd_pkg::CSR_DATA_W'(cfg_ff.zero_min);
         ipd_pkg::ADDR_ZERO_MAX:   prdata = ipd_pkg::CSR_DATA_W'(cfg_ff.zero_max);
         default:                  prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control: input register, then output register
   // ---------------------------------------------------------------------
   logic                        in_valid_ff;
   logic [ipd_pkg::STAMP_W-1:0] edge_ff;
   logic                        out_valid_ff;
   logic                        advance;
   logic                        step;

   // The output register can load when it is empty or being drained.
   assign advance   = !out_valid_ff || rsp.ready;
   assign step      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         edge_ff <= req.edge_time;
      end
   end

   // ---------------------------------------------------------------------
   // Decoder state
   // ---------------------------------------------------------------------
   ipd_pkg::phase_type          phase_ff, phase_in;
   logic [ipd_pkg::STAMP_W-1:0] earlier_ff, earlier_in;
   logic [ipd_pkg::STAMP_W-1:0] latest_ff, latest_in;
   logic [ipd_pkg::VALUE_W-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        ready_ff, ready_in;
   logic                        done_in;
   logic                        rejected_in;
   logic [ipd_pkg::STAMP_W-1:0] prev_stamp;
   ipd_pkg::match_type          match;

   // While receiving, the interval runs from the last bit edge; while waiting
   // to close the leader, it runs from the stored leader start edge.
   assign prev_stamp = (phase_ff == ipd_pkg::PH_RECV) ? latest_ff : earlier_ff;

   ipd_classify u_classify (
      .prev_stamp (prev_stamp),
      .cur_stamp  (edge_ff),
      .cfg        (cfg_ff),
      .match      (match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ipd_pkg::PH_IDLE;
         earlier_ff <= '0;
         latest_ff  <= '0;
         shift_ff   <= '0;
         count_ff   <= '0;
         ready_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         earlier_ff <= earlier_in;
         latest_ff  <= latest_in;
         shift_ff   <= shift_in;
         count_ff   <= count_in;
         ready_ff   <= ready_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      earlier_in  = earlier_ff;
      latest_in   = latest_ff;
      shift_in    = shift_ff;
      count_in    = count_ff;
      ready_in    = ready_ff;
      done_in     = 1'b0;
      rejected_in = 1'b0;
      if (step) begin
         unique case (phase_ff)
            ipd_pkg::PH_RECV: begin
               earlier_in = latest_ff;
               latest_in  = edge_ff;
               // The one window wins where the two bit windows overlap.
               priority if (match.one_hit) begin
                  shift_in = {shift_ff[ipd_pkg::VALUE_W-2:0], 1'b1};
                  count_in = count_ff + 1'b1;
               end else if (match.zero_hit) begin
                  shift_in = {shift_ff[ipd_pkg::VALUE_W-2:0], 1'b0};
                  count_in = count_ff + 1'b1;
               end else begin
                  phase_in    = ipd_pkg::PH_IDLE;
                  count_in    = '0;
                  rejected_in = 1'b1;
               end
               if (!rejected_in && (count_in == CNT_W'(FRAME_BITS))) begin
                  ready_in = 1'b1;
                  phase_in = ipd_pkg::PH_IDLE;
                  count_in = '0;
                  done_in  = 1'b1;
               end
            end
            ipd_pkg::PH_FIRST: begin
               latest_in = edge_ff;
               if (match.leader_hit) begin
                  phase_in = ipd_pkg::PH_RECV;
                  shift_in = '0;
                  ready_in = 1'b0;
                  count_in = '0;
               end else begin
                  // Both leader edges are dropped.
                  phase_in    = ipd_pkg::PH_IDLE;
                  rejected_in = 1'b1;
               end
            end
            default: begin
               // Idle, and the unused phase code: store a first edge.
               earlier_in = edge_ff;
               phase_in   = ipd_pkg::PH_FIRST;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic                        frame_ready_ff;
   logic [ipd_pkg::VALUE_W-1:0] frame_value_ff;
   logic                        frame_done_ff;
   logic                        pulse_rejected_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         frame_ready_ff    <= ready_in;
         frame_value_ff    <= ready_in ? shift_in : '0;
         frame_done_ff     <= done_in;
         pulse_rejected_ff <= rejected_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.frame_ready    = frame_ready_ff;
   assign rsp.frame_value    = frame_value_ff;
   assign rsp.frame_done     = frame_done_ff;
   assign rsp.pulse_rejected = pulse_rejected_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // An edge cannot both complete a frame and be rejected.
   a_done_xor_reject: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.frame_done && rsp.pulse_rejected))
      else $error("frame_done and pulse_rejected both set");

   // A completed frame is always reported as held.
   a_done_sets_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.frame_done) |-> rsp.frame_ready)
      else $error("frame_done without frame_ready");

   // No code leaks out while no frame is held.
   a_value_masked: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.frame_ready) |-> (rsp.frame_value == '0))
      else $error("frame_value nonzero without frame_ready");

   // The bit counter never runs past the frame length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(FRAME_BITS))
      else $error("bit count reached frame length without completing");

   // Completing a frame returns the decoder to idle.
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (step && done_in) |=> (phase_ff == ipd_pkg::PH_IDLE))
      else $error("decoder not idle after frame completion");

endmodule

`default_nettype wire
